### hdl/psev_pkg.sv
// shared types and constants of the postfix stack evaluator
// no dependencies; used by every module under hdl

package psev_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_VARS    = 16;

    localparam int DATA_W  = 64;
    localparam int HALF_W  = DATA_W / 2;
    localparam int WIDTH_W = 7;
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int VAR_AW  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(DATA_W);

    typedef enum logic [3:0] {
        OP_LOAD  = 4'd0,
        OP_PUSHC = 4'd1,
        OP_PUSHV = 4'd2,
        OP_NOT   = 4'd3,
        OP_NEG   = 4'd4,
        OP_SHR   = 4'd5,
        OP_ADD   = 4'd6,
        OP_MUL   = 4'd7,
        OP_AND   = 4'd8,
        OP_OR    = 4'd9,
        OP_XOR   = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    // what a stack cell loads at the next edge
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_ABOVE = 2'd1,
        CELL_BELOW = 2'd2
    } t_cell_cmd;

    typedef struct packed {
        logic              start;
        logic              last;
        t_status           err;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] mask;
    } t_mul_req;

    typedef struct packed {
        logic              valid;
        logic              last;
        t_status           err;
        logic [DATA_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        t_status           status;
    } t_res;

endpackage

### hdl/postfix_stack_evaluator.sv
// top level of the postfix stack evaluator
// depends on psev_pkg, psev_cell, psev_mul, psev_outq

// Runs a postfix program one instruction per transfer on a stack of
// STACK_DEPTH cells that shift as a chain, the top in cell 0. A mul
// builds its 64-bit product from 32x32 partial products that the
// multiplier registers, and o_in_stall is high for the cycle in which
// the product is written back. The result of a last instruction goes
// into a two-entry output queue, so instructions keep flowing while one
// result waits; besides the write-back, the input stalls only when both
// entries are full. i_cfg_data sets the arithmetic width (values above
// 64 act as 64); the user must write it only between programs or while
// no instruction is in flight, which the block does not enforce.

module postfix_stack_evaluator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [psev_pkg::WIDTH_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [3:0]                    i_req_type,
    input  logic [3:0]                    i_var_sel,
    input  logic [psev_pkg::DATA_W-1:0]   i_operand,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [psev_pkg::DATA_W-1:0]   o_result,
    output logic [1:0]                    o_status
);

    localparam int DW    = psev_pkg::DATA_W;
    localparam int DEPTH = psev_pkg::STACK_DEPTH;
    localparam int SPW   = psev_pkg::SP_W;
    localparam int WW    = psev_pkg::WIDTH_W;
    localparam logic [WW-1:0] W_MAX = WW'(DW);

    logic [psev_pkg::WIDTH_W-1:0] r_bit_width;
    logic [SPW-1:0]               r_sp;
    psev_pkg::t_status            r_err;
    logic [DW-1:0]                r_vars [psev_pkg::NUM_VARS];

    logic [SPW-1:0]      n_sp;
    psev_pkg::t_status   n_err;
    logic [DW-1:0]       stk_q [DEPTH];
    psev_pkg::t_cell_cmd cmd_top;
    psev_pkg::t_cell_cmd cmd_rest;
    logic                top_wr;
    logic [DW-1:0]       top_val;
    logic [DW-1:0]       top_after;

    psev_pkg::t_mul_req mul_req;
    psev_pkg::t_mul_rsp mul_rsp;
    logic               res_push;
    psev_pkg::t_res     res_in;
    psev_pkg::t_res     res_out;
    logic               q_full;

    logic                         acc;
    psev_pkg::t_op                op;
    logic [psev_pkg::WIDTH_W-1:0] eff_w;
    logic [DW-1:0]                mask;
    logic [DW-1:0]                top_m;
    logic                         var_ok;
    logic [psev_pkg::VAR_AW-1:0]  var_idx;
    logic                         var_we;
    logic                         has1;
    logic                         has2;
    logic                         full;

    assign acc     = i_in_valid && !o_in_stall;
    assign op      = psev_pkg::t_op'(i_req_type);
    assign var_ok  = 32'(i_var_sel) < psev_pkg::NUM_VARS;
    assign var_idx = psev_pkg::VAR_AW'(i_var_sel);
    assign has1    = r_sp >= SPW'(1);
    assign has2    = r_sp >= SPW'(2);
    assign full    = r_sp >= SPW'(DEPTH);

    always_comb begin
        eff_w = (r_bit_width > W_MAX) ? W_MAX : r_bit_width;
        mask  = (eff_w >= W_MAX) ? {DW{1'b1}} : ((DW'(1) << eff_w) - DW'(1));
        top_m = stk_q[0] & mask;
    end

    always_comb begin
        n_sp          = r_sp;
        n_err         = r_err;
        top_wr        = 1'b0;
        top_val       = '0;
        cmd_rest      = psev_pkg::CELL_HOLD;
        var_we        = 1'b0;
        mul_req.start = 1'b0;
        mul_req.last  = i_last;
        mul_req.err   = r_err;
        mul_req.a     = stk_q[1];
        mul_req.b     = stk_q[0];
        mul_req.mask  = mask;
        res_push      = 1'b0;
        res_in.result = '0;
        res_in.status = psev_pkg::ST_OK;

        if (mul_rsp.valid) begin
            // product write-back; no transfer is taken in this cycle
            top_wr   = 1'b1;
            top_val  = mul_rsp.prod;
            res_push = mul_rsp.last;
            if (mul_rsp.err != psev_pkg::ST_OK) begin
                res_in.status = mul_rsp.err;
            end else begin
                res_in.result = mul_rsp.prod;
            end
        end else if (acc) begin
            unique case (op)
                psev_pkg::OP_LOAD: begin
                    var_we = var_ok;
                end
                psev_pkg::OP_PUSHC, psev_pkg::OP_PUSHV: begin
                    if (full) begin
                        if (n_err == psev_pkg::ST_OK) n_err = psev_pkg::ST_OVER;
                    end else begin
                        top_wr   = 1'b1;
                        cmd_rest = psev_pkg::CELL_ABOVE;
                        n_sp     = r_sp + SPW'(1);
                        if (op == psev_pkg::OP_PUSHC) begin
                            top_val = i_operand & mask;
                        end else begin
                            top_val = var_ok ? (r_vars[var_idx] & mask) : '0;
                        end
                    end
                end
                psev_pkg::OP_NOT, psev_pkg::OP_NEG, psev_pkg::OP_SHR: begin
                    if (!has1) begin
                        if (n_err == psev_pkg::ST_OK) n_err = psev_pkg::ST_UNDER;
                    end else begin
                        top_wr = 1'b1;
                        if (op == psev_pkg::OP_NOT) begin
                            top_val = ~top_m & mask;
                        end else if (op == psev_pkg::OP_NEG) begin
                            top_val = (DW'(0) - top_m) & mask;
                        end else if (i_operand >= DW'(eff_w)) begin
                            top_val = '0;
                        end else begin
                            top_val = (top_m >> i_operand[5:0]) & mask;
                        end
                    end
                end
                psev_pkg::OP_MUL: begin
                    if (!has2) begin
                        if (n_err == psev_pkg::ST_OK) n_err = psev_pkg::ST_UNDER;
                    end else begin
                        mul_req.start = 1'b1;
                        cmd_rest      = psev_pkg::CELL_BELOW;
                        n_sp          = r_sp - SPW'(1);
                    end
                end
                psev_pkg::OP_ADD, psev_pkg::OP_AND, psev_pkg::OP_OR,
                psev_pkg::OP_XOR: begin
                    if (!has2) begin
                        if (n_err == psev_pkg::ST_OK) n_err = psev_pkg::ST_UNDER;
                    end else begin
                        top_wr   = 1'b1;
                        cmd_rest = psev_pkg::CELL_BELOW;
                        n_sp     = r_sp - SPW'(1);
                        if (op == psev_pkg::OP_ADD) begin
                            top_val = (stk_q[1] + stk_q[0]) & mask;
                        end else if (op == psev_pkg::OP_AND) begin
                            top_val = stk_q[1] & stk_q[0] & mask;
                        end else if (op == psev_pkg::OP_OR) begin
                            top_val = (stk_q[1] | stk_q[0]) & mask;
                        end else begin
                            top_val = (stk_q[1] ^ stk_q[0]) & mask;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (i_last) begin
                // a multiply reports through its write-back cycle instead
                res_push = !mul_req.start;
                if (n_err != psev_pkg::ST_OK) begin
                    res_in.status = n_err;
                end else if (n_sp == '0) begin
                    res_in.status = psev_pkg::ST_UNDER;
                end else begin
                    res_in.result = top_after & mask;
                end
                n_sp  = '0;
                n_err = psev_pkg::ST_OK;
            end
        end
    end

    assign top_after = top_wr ? top_val : stk_q[0];
    assign cmd_top   = top_wr ? psev_pkg::CELL_ABOVE : psev_pkg::CELL_HOLD;

    // stack cells, cell 0 is the top
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [DW-1:0] above;
        logic [DW-1:0] below;
        if (gi == 0) begin : g_head
            assign above = top_val;
        end else begin : g_body
            assign above = stk_q[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_tail
            assign below = '0;
        end else begin : g_link
            assign below = stk_q[gi+1];
        end
        psev_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   ((gi == 0) ? cmd_top : cmd_rest),
            .i_above (above),
            .i_below (below),
            .o_q     (stk_q[gi])
        );
    end

    psev_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    psev_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_push),
        .i_res       (res_in),
        .o_full      (q_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res_out)
    );

    assign o_in_stall = mul_rsp.valid || q_full;
    assign o_result   = res_out.result;
    assign o_status   = res_out.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_width <= psev_pkg::WIDTH_RESET;
            r_sp        <= '0;
            r_err       <= psev_pkg::ST_OK;
        end else begin
            if (i_cfg_we) r_bit_width <= i_cfg_data;
            r_sp  <= n_sp;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (var_we) r_vars[var_idx] <= i_operand;
    end

`ifndef SYNTHESIS
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(DEPTH))
        else $error("stack pointer beyond stack depth");

    a_mul_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.valid |-> o_in_stall)
        else $error("transfer possible during multiply write-back");

    a_mul_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && op == psev_pkg::OP_MUL && has2) |=> mul_rsp.valid)
        else $error("accepted multiply did not reach write-back");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_last) |=> (r_sp == '0 && r_err == psev_pkg::ST_OK))
        else $error("stack not emptied after last instruction");
`endif

endmodule

### hdl/psev_cell.sv
// one entry of the shift-register value stack
// depends on psev_pkg

module psev_cell (
    input  logic                        i_clk,
    input  psev_pkg::t_cell_cmd         i_cmd,
    input  logic [psev_pkg::DATA_W-1:0] i_above,
    input  logic [psev_pkg::DATA_W-1:0] i_below,
    output logic [psev_pkg::DATA_W-1:0] o_q
);

    logic [psev_pkg::DATA_W-1:0] r_q;
    logic [psev_pkg::DATA_W-1:0] n_q;

    always_comb begin
        unique case (i_cmd)
            psev_pkg::CELL_ABOVE: n_q = i_above;
            psev_pkg::CELL_BELOW: n_q = i_below;
            psev_pkg::CELL_HOLD:  n_q = r_q;
            default:              n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

### hdl/psev_mul.sv
// registered 64-bit multiplier, low half of the product only
// depends on psev_pkg; partial products from 32x32 multipliers

module psev_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psev_pkg::t_mul_req i_req,
    output psev_pkg::t_mul_rsp o_rsp
);

    localparam int HW = psev_pkg::HALF_W;
    localparam int DW = psev_pkg::DATA_W;

    logic              r_busy;
    logic [DW-1:0]     r_pp0;
    logic [HW-1:0]     r_cross;
    logic [DW-1:0]     r_mask;
    logic              r_last;
    psev_pkg::t_status r_err;

    logic [DW-1:0] n_pp0;
    logic [HW-1:0] n_c1;
    logic [HW-1:0] n_c2;
    logic [HW-1:0] n_cross;

    always_comb begin
        n_pp0   = i_req.a[HW-1:0] * i_req.b[HW-1:0];
        // cross terms only reach the upper half, so their low halves suffice
        n_c1    = i_req.a[HW-1:0] * i_req.b[DW-1:HW];
        n_c2    = i_req.a[DW-1:HW] * i_req.b[HW-1:0];
        n_cross = n_c1 + n_c2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_req.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_pp0   <= n_pp0;
            r_cross <= n_cross;
            r_mask  <= i_req.mask;
            r_last  <= i_req.last;
            r_err   <= i_req.err;
        end
    end

    always_comb begin
        o_rsp.valid = r_busy;
        o_rsp.last  = r_last;
        o_rsp.err   = r_err;
        o_rsp.prod  = (r_pp0 + {r_cross, {HW{1'b0}}}) & r_mask;
    end

endmodule

### hdl/psev_outq.sv
// two-entry result queue: output register plus skid entry
// depends on psev_pkg

module psev_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  psev_pkg::t_res i_res,
    output logic           o_full,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output psev_pkg::t_res o_res
);

    logic           r_out_valid;
    logic           r_skd_valid;
    psev_pkg::t_res r_out;
    psev_pkg::t_res r_skd;

    logic           n_out_valid;
    logic           n_skd_valid;
    psev_pkg::t_res n_out;
    psev_pkg::t_res n_skd;
    logic           out_free;

    always_comb begin
        out_free    = !r_out_valid || !i_out_stall;
        n_out_valid = r_out_valid;
        n_skd_valid = r_skd_valid;
        n_out       = r_out;
        n_skd       = r_skd;
        if (out_free) begin
            if (r_skd_valid) begin
                n_out       = r_skd;
                n_out_valid = 1'b1;
                n_skd       = i_res;
                n_skd_valid = i_push;
            end else begin
                n_out       = i_res;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skd       = i_res;
            n_skd_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_skd_valid <= n_skd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skd <= n_skd;
    end

    assign o_full      = r_skd_valid;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule
